/* hdl/intel_hex_page_loader_defines.svh */
// assertion helpers shared by the checking code
`ifndef INTEL_HEX_PAGE_LOADER_DEFINES_SVH
`define INTEL_HEX_PAGE_LOADER_DEFINES_SVH

// same-cycle implication
`define IHPL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define IHPL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/ihpl_pkg.sv */
package ihpl_pkg;

  localparam logic [2:0] KIND_LOAD   = 3'd1;
  localparam logic [2:0] KIND_WRITE  = 3'd2;
  localparam logic [2:0] KIND_ACCEPT = 3'd3;
  localparam logic [2:0] KIND_REJECT = 3'd4;

  localparam logic [7:0] CHAR_CR     = 8'd13;
  localparam logic [7:0] CHAR_COLON  = 8'h3a;
  localparam logic [7:0] BYTE_ERASED = 8'hff;

  localparam int CMD_LEN_W = 6;

  typedef enum logic [1:0] {
    OP_REJECT,
    OP_DATA,
    OP_EOF
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic [15:0]          addr;
    logic [CMD_LEN_W-1:0] len;
  } cmd_t;

  // {valid, nibble}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c inside {[8'h41:8'h46]}) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c inside {[8'h61:8'h66]}) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

endpackage

/* hdl/ihpl_ram.sv */
module ihpl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/ihpl_fifo.sv */
module ihpl_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  ihpl_pkg::cmd_t push_cmd,
  input  logic          pop,
  output ihpl_pkg::cmd_t pop_cmd,
  output logic          full,
  output logic          empty
);
  import ihpl_pkg::*;

  cmd_t       ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == 2'd2);
  assign empty   = (cnt_r == 2'd0);
  assign pop_cmd = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = ~wp_r;
    end
    if (pop) begin
      rp_nxt = ~rp_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= push_cmd;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* hdl/ihpl_front.sv */
module ihpl_front #(
  parameter int PAGE_BYTES     = 32,
  parameter int MAX_DATA_BYTES = 16,
  parameter int REC_AW         = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_char_code,
  input  logic              in_prog_enabled,
  input  logic              q_full,
  input  logic              lock,
  output logic              push,
  output ihpl_pkg::cmd_t     push_cmd,
  output logic              rec_we,
  output logic [REC_AW-1:0] rec_waddr,
  output logic [7:0]        rec_wdata
);
  import ihpl_pkg::*;

  localparam int PAGE_AW = $clog2(PAGE_BYTES);
  localparam int DC_W    = $clog2(2 * (MAX_DATA_BYTES + 5));
  localparam int IDX_W   = DC_W - 1;
  localparam int CNT_W   = $clog2(MAX_DATA_BYTES + 1);
  localparam int RNG_W   = PAGE_AW + 2;

  logic             line_start_r, line_start_nxt;
  logic             in_rec_r, in_rec_nxt;
  logic [DC_W-1:0]  dc_r, dc_nxt;
  logic [3:0]       hi_r, hi_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       sum_r, sum_nxt;

  logic [4:0]       dec;
  logic             is_hex;
  logic [7:0]       byte_v;
  logic [IDX_W-1:0] idx;
  logic [IDX_W-1:0] last_idx;
  logic             data_pos;
  logic             acc;
  logic             ended;
  logic [7:0]       sum_all;
  logic             range_bad;

  assign dec      = hex_decode(in_char_code);
  assign is_hex   = dec[4];
  assign byte_v   = {hi_r, dec[3:0]};
  assign idx      = dc_r[DC_W-1:1];
  assign last_idx = IDX_W'(cnt_r) + IDX_W'(4);
  assign data_pos = dc_r[0] && (idx >= IDX_W'(4)) && (idx < last_idx);
  assign sum_all  = sum_r + byte_v;
  assign range_bad = (RNG_W'(addr_r[PAGE_AW-1:0]) + RNG_W'(cnt_r)) > RNG_W'(PAGE_BYTES);

  // data bytes wait while the back end may still read the record buffer
  assign in_stall = in_rec_r && (q_full || (data_pos && lock));
  assign acc      = in_valid && !in_stall;

  assign rec_we    = acc && in_rec_r && is_hex && data_pos;
  assign rec_waddr = REC_AW'(idx - IDX_W'(4));
  assign rec_wdata = byte_v;

  always_comb begin
    line_start_nxt = line_start_r;
    in_rec_nxt     = in_rec_r;
    dc_nxt         = dc_r;
    hi_nxt         = hi_r;
    cnt_nxt        = cnt_r;
    addr_nxt       = addr_r;
    type_nxt       = type_r;
    sum_nxt        = sum_r;
    ended          = 1'b0;
    push           = 1'b0;
    push_cmd.op    = OP_REJECT;
    push_cmd.addr  = addr_r;
    push_cmd.len   = CMD_LEN_W'(cnt_r);
    if (acc) begin
      if (!in_rec_r) begin
        if (in_char_code == CHAR_CR) begin
          line_start_nxt = 1'b1;
        end else begin
          if (line_start_r && (in_char_code == CHAR_COLON)) begin
            in_rec_nxt = 1'b1;
            dc_nxt     = '0;
          end
          line_start_nxt = 1'b0;
        end
      end else if (!is_hex) begin
        ended = 1'b1;
      end else if (!dc_r[0]) begin
        hi_nxt = dec[3:0];
        dc_nxt = dc_r + DC_W'(1);
      end else begin
        dc_nxt = dc_r + DC_W'(1);
        if (idx == '0) begin
          cnt_nxt = CNT_W'(byte_v);
          sum_nxt = byte_v;
          if (byte_v > 8'(MAX_DATA_BYTES)) begin
            ended = 1'b1;
          end
        end else begin
          sum_nxt = sum_all;
          if (idx == IDX_W'(1)) begin
            addr_nxt[15:8] = byte_v;
          end
          if (idx == IDX_W'(2)) begin
            addr_nxt[7:0] = byte_v;
          end
          if (idx == IDX_W'(3)) begin
            type_nxt = byte_v;
          end
          if (idx == last_idx) begin
            ended = 1'b1;
            if (in_prog_enabled && (sum_all == 8'd0) && !range_bad) begin
              if (type_r == 8'd0) begin
                push_cmd.op = OP_DATA;
              end else if (type_r == 8'd1) begin
                push_cmd.op = OP_EOF;
              end
            end
          end
        end
      end
      if (ended) begin
        push           = 1'b1;
        in_rec_nxt     = 1'b0;
        line_start_nxt = 1'b1;
        dc_nxt         = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi_r   <= hi_nxt;
    cnt_r  <= cnt_nxt;
    addr_r <= addr_nxt;
    type_r <= type_nxt;
    sum_r  <= sum_nxt;
    if (!rst_n) begin
      line_start_r <= 1'b1;
      in_rec_r     <= 1'b0;
      dc_r         <= '0;
    end else begin
      line_start_r <= line_start_nxt;
      in_rec_r     <= in_rec_nxt;
      dc_r         <= dc_nxt;
    end
  end

endmodule

/* hdl/ihpl_back.sv */
module ihpl_back #(
  parameter int PAGE_BYTES = 32,
  parameter int REC_AW     = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  ihpl_pkg::cmd_t     q_cmd,
  output logic              pop,
  output logic              busy,
  output logic              rec_re,
  output logic [REC_AW-1:0] rec_raddr,
  input  logic [7:0]        rec_rdata,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_kind,
  output logic [15:0]       out_address,
  output logic [7:0]        out_data,
  output logic              out_last
);
  import ihpl_pkg::*;

  localparam int PAGE_AW = $clog2(PAGE_BYTES);
  localparam logic [PAGE_AW-1:0] PAGE_LAST = PAGE_AW'(PAGE_BYTES - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FRD  = 3'd1;
  localparam logic [2:0] S_FOUT = 3'd2;
  localparam logic [2:0] S_FWR  = 3'd3;
  localparam logic [2:0] S_CLR  = 3'd4;
  localparam logic [2:0] S_CRD  = 3'd5;
  localparam logic [2:0] S_CWR  = 3'd6;
  localparam logic [2:0] S_RES  = 3'd7;

  logic [2:0]            st_r, st_nxt;
  cmd_t                  cmd_r, cmd_nxt;
  logic                  pv_r, pv_nxt;
  logic [15:0]           pb_r, pb_nxt;
  logic [PAGE_AW-1:0]    fidx_r, fidx_nxt;
  logic [CMD_LEN_W-1:0]  cidx_r, cidx_nxt;
  logic                  ok_r, ok_nxt;
  logic [PAGE_BYTES-1:0] pvalid_r, pvalid_nxt;
  logic                  ov_r, ov_nxt;
  logic [2:0]            okind_r, okind_nxt;
  logic [15:0]           oaddr_r, oaddr_nxt;
  logic [7:0]            odata_r, odata_nxt;
  logic                  olast_r, olast_nxt;

  logic                  out_free;
  logic [15:0]           qbase;
  logic [15:0]           cbase;
  logic                  pg_we;
  logic [PAGE_AW-1:0]    pg_waddr;
  logic                  pg_re;
  logic [7:0]            pg_rdata;

  assign out_free = !ov_r || !out_stall;
  assign qbase    = {q_cmd.addr[15:PAGE_AW], {PAGE_AW{1'b0}}};
  assign cbase    = {cmd_r.addr[15:PAGE_AW], {PAGE_AW{1'b0}}};
  assign busy     = (st_r != S_IDLE);
  assign pg_re    = (st_r == S_FRD);
  assign pg_we    = (st_r == S_CWR);
  assign pg_waddr = cmd_r.addr[PAGE_AW-1:0] + PAGE_AW'(cidx_r);
  assign rec_re   = (st_r == S_CRD);
  assign rec_raddr = REC_AW'(cidx_r);

  ihpl_ram #(
    .WIDTH(8),
    .DEPTH(PAGE_BYTES)
  ) u_page_ram (
    .clk  (clk),
    .we   (pg_we),
    .waddr(pg_waddr),
    .wdata(rec_rdata),
    .re   (pg_re),
    .raddr(fidx_r),
    .rdata(pg_rdata)
  );

  always_comb begin
    st_nxt     = st_r;
    cmd_nxt    = cmd_r;
    pv_nxt     = pv_r;
    pb_nxt     = pb_r;
    fidx_nxt   = fidx_r;
    cidx_nxt   = cidx_r;
    ok_nxt     = ok_r;
    pvalid_nxt = pvalid_r;
    ov_nxt     = ov_r && out_stall;
    okind_nxt  = okind_r;
    oaddr_nxt  = oaddr_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    pop        = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (!q_empty) begin
          pop      = 1'b1;
          cmd_nxt  = q_cmd;
          fidx_nxt = '0;
          cidx_nxt = '0;
          ok_nxt   = 1'b1;
          case (q_cmd.op)
            OP_EOF: begin
              st_nxt = pv_r ? S_FRD : S_CLR;
            end
            OP_DATA: begin
              if (!pv_r || (qbase != pb_r)) begin
                st_nxt = pv_r ? S_FRD : S_CLR;
              end else begin
                st_nxt = (q_cmd.len == '0) ? S_RES : S_CRD;
              end
            end
            default: begin
              ok_nxt = 1'b0;
              st_nxt = S_RES;
            end
          endcase
        end
      end
      S_FRD: begin
        st_nxt = S_FOUT;
      end
      S_FOUT: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_LOAD;
          oaddr_nxt = {pb_r[15:PAGE_AW], fidx_r};
          odata_nxt = pvalid_r[fidx_r] ? pg_rdata : BYTE_ERASED;
          olast_nxt = 1'b0;
          if (fidx_r == PAGE_LAST) begin
            st_nxt = S_FWR;
          end else begin
            fidx_nxt = fidx_r + PAGE_AW'(1);
            st_nxt   = S_FRD;
          end
        end
      end
      S_FWR: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = KIND_WRITE;
          oaddr_nxt = pb_r;
          odata_nxt = 8'd0;
          olast_nxt = 1'b0;
          st_nxt    = S_CLR;
        end
      end
      S_CLR: begin
        pvalid_nxt = '0;
        if (cmd_r.op == OP_DATA) begin
          pb_nxt = cbase;
          pv_nxt = 1'b1;
          st_nxt = (cmd_r.len == '0) ? S_RES : S_CRD;
        end else begin
          pv_nxt = 1'b0;
          st_nxt = S_RES;
        end
      end
      S_CRD: begin
        st_nxt = S_CWR;
      end
      S_CWR: begin
        pvalid_nxt[pg_waddr] = 1'b1;
        if (cidx_r == (cmd_r.len - CMD_LEN_W'(1))) begin
          st_nxt = S_RES;
        end else begin
          cidx_nxt = cidx_r + CMD_LEN_W'(1);
          st_nxt   = S_CRD;
        end
      end
      S_RES: begin
        if (out_free) begin
          ov_nxt    = 1'b1;
          okind_nxt = ok_r ? KIND_ACCEPT : KIND_REJECT;
          oaddr_nxt = 16'd0;
          odata_nxt = 8'd0;
          olast_nxt = 1'b1;
          st_nxt    = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    fidx_r  <= fidx_nxt;
    cidx_r  <= cidx_nxt;
    ok_r    <= ok_nxt;
    okind_r <= okind_nxt;
    oaddr_r <= oaddr_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
    if (!rst_n) begin
      st_r     <= S_IDLE;
      pv_r     <= 1'b0;
      pb_r     <= 16'd0;
      pvalid_r <= '0;
      ov_r     <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      pv_r     <= pv_nxt;
      pb_r     <= pb_nxt;
      pvalid_r <= pvalid_nxt;
      ov_r     <= ov_nxt;
    end
  end

  assign out_valid   = ov_r;
  assign out_kind    = okind_r;
  assign out_address = oaddr_r;
  assign out_data    = odata_r;
  assign out_last    = olast_r;

endmodule

/* hdl/intel_hex_page_loader.sv */
// Intel HEX page loader.
// Input channel (in_valid / in_stall): one received character a word, with
// in_prog_enabled sampled alongside. Result channel (out_valid / out_stall):
// page byte loads, page writes and one accepted or rejected word per record;
// out_last marks the final word caused by a character.
// A parser takes one character per cycle while in_stall is low and hands
// each finished record as a command to a two-entry queue; an executor
// carries it out. A page flush reads each page byte from the page RAM,
// then puts it in the output register, and ends with a page write word;
// copying data into the page reads each data byte from the record RAM,
// then writes it to the page RAM. Characters outside records never wait;
// a data digit of a new record waits while earlier record work is pending,
// and any record character waits while the queue is full.
// Reset returns the parser to line start and marks every page byte as
// erased (0xFF) through per-byte valid flags, so no clearing pass is needed.
// A stalled receiver holds the output register, and the executor waits at its next output word.
module intel_hex_page_loader #(
  parameter int PAGE_BYTES     = 32,
  parameter int MAX_DATA_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char_code,
  input  logic        in_prog_enabled,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [15:0] out_address,
  output logic [7:0]  out_data,
  output logic        out_last
);
  import ihpl_pkg::*;

  localparam int REC_AW = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;

  logic              q_push;
  cmd_t              q_push_cmd;
  logic              q_pop;
  cmd_t              q_pop_cmd;
  logic              q_full;
  logic              q_empty;
  logic              back_busy;
  logic              lock;
  logic              rec_we;
  logic [REC_AW-1:0] rec_waddr;
  logic [7:0]        rec_wdata;
  logic              rec_re;
  logic [REC_AW-1:0] rec_raddr;
  logic [7:0]        rec_rdata;

  assign lock = back_busy || !q_empty;

  ihpl_front #(
    .PAGE_BYTES    (PAGE_BYTES),
    .MAX_DATA_BYTES(MAX_DATA_BYTES),
    .REC_AW        (REC_AW)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_char_code   (in_char_code),
    .in_prog_enabled(in_prog_enabled),
    .q_full         (q_full),
    .lock           (lock),
    .push           (q_push),
    .push_cmd       (q_push_cmd),
    .rec_we         (rec_we),
    .rec_waddr      (rec_waddr),
    .rec_wdata      (rec_wdata)
  );

  ihpl_ram #(
    .WIDTH(8),
    .DEPTH(MAX_DATA_BYTES)
  ) u_rec_ram (
    .clk  (clk),
    .we   (rec_we),
    .waddr(rec_waddr),
    .wdata(rec_wdata),
    .re   (rec_re),
    .raddr(rec_raddr),
    .rdata(rec_rdata)
  );

  ihpl_fifo u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_cmd(q_push_cmd),
    .pop     (q_pop),
    .pop_cmd (q_pop_cmd),
    .full    (q_full),
    .empty   (q_empty)
  );

  ihpl_back #(
    .PAGE_BYTES(PAGE_BYTES),
    .REC_AW    (REC_AW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_empty    (q_empty),
    .q_cmd      (q_pop_cmd),
    .pop        (q_pop),
    .busy       (back_busy),
    .rec_re     (rec_re),
    .rec_raddr  (rec_raddr),
    .rec_rdata  (rec_rdata),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_kind   (out_kind),
    .out_address(out_address),
    .out_data   (out_data),
    .out_last   (out_last)
  );

`include "intel_hex_page_loader_defines.svh"

  `IHPL_ASSERT_IMP(a_last_on_verdict, out_valid, out_last == ((out_kind == KIND_ACCEPT) || (out_kind == KIND_REJECT)), "last flag does not match word kind")
  `IHPL_ASSERT_IMP(a_queue_no_overflow, q_push, !q_full, "command pushed into full queue")
  `IHPL_ASSERT_IMP(a_rec_write_safe, rec_we, !back_busy && q_empty, "record buffer written while in use")
  `IHPL_ASSERT_NXT(a_pop_starts_work, q_pop, back_busy, "popped command not taken up")

endmodule
